/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] size;
      logic [31:0] ident;
      logic        busy;
   } entry_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_BADID   = 3'd3;
   localparam logic [2:0] ST_BADSIZE = 3'd4;

   localparam logic       FUNC_ALLOC = 1'b0;
   localparam logic       FUNC_FREE  = 1'b1;

   localparam logic [31:0] TOTAL_RESET = 32'd268435456;
   localparam logic [31:0] SIZE_MASK   = 32'hFFFF_FFC0;

   // shared adder operation
   typedef struct packed {
      logic [32:0] a;
      logic [32:0] b;
      logic        sub;
   } add_op_type;

endpackage

/* hw/rtl/ffba_adder.sv */
// ----------------------------------------------------------------------------
// ffba_adder
// Shared 33-bit add/subtract unit used by several steps of the sequencer.
// ----------------------------------------------------------------------------
module ffba_adder (
   input  ffba_pkg::add_op_type op,
   output logic [33:0]          sum
);

   logic [32:0] b_eff;

   assign b_eff = op.sub ? ~op.b : op.b;
   assign sum   = {1'b0, op.a} + {1'b0, b_eff} + {33'd0, op.sub};

endmodule

/* hw/rtl/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffba_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ffba_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ffba_pkg::entry_type rd_data
);

   ffba_pkg::entry_type mem [DEPTH];
   ffba_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an offset-ordered block table with merging of
// free neighbors on release.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | func, size, alignment, free id
//  rsp     | out       | rsp_valid/rsp_ready   | status, offset, size, id, used
//  csr     | in        | csr_valid/csr_ready   | total_bytes
//
//  Allocate: read, pad, compare per scanned entry; read, write per split shift.
//  Free: read, compare per scanned entry; read, write per entry moved on a merge.
//  Worst case grows with MAX_ENTRIES, set by the single table port.
//  After reset or a csr write, the S_INIT state writes the initial table entry.
//  req_ready is high only when the sequencer is idle; a result waiting on
//  rsp holds the next request only at its final step.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_req_size,
   input  logic [4:0]  req_align_log2,
   input  logic [31:0] req_free_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_granted_size,
   output logic [31:0] rsp_block_id,
   output logic [31:0] rsp_used_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_total_bytes
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] ONE     = CW'(1);

   typedef enum logic [20:0] {
      S_INIT   = 21'h000001,
      S_IDLE   = 21'h000002,
      S_A_RD   = 21'h000004,
      S_A_PAD  = 21'h000008,
      S_A_CMP  = 21'h000010,
      S_A_DEC  = 21'h000020,
      S_SH_RD  = 21'h000040,
      S_SH_WR  = 21'h000080,
      S_A_REST = 21'h000100,
      S_A_WR1  = 21'h000200,
      S_A_WR0  = 21'h000400,
      S_F_RD   = 21'h000800,
      S_F_CMP  = 21'h001000,
      S_F_PRD  = 21'h002000,
      S_F_PCAP = 21'h004000,
      S_F_NCAP = 21'h008000,
      S_F_MRG  = 21'h010000,
      S_F_MRG2 = 21'h020000,
      S_C_RD   = 21'h040000,
      S_C_WR   = 21'h080000,
      S_OUT    = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]   total_ff, total_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   next_id_ff, next_id_in;
   logic [31:0]   used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] found_ff, found_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]    rm_ff, rm_in;
   logic          pf_ff, pf_in;
   logic          nf_ff, nf_in;

   logic [31:0]   size_ff, size_in;
   logic [31:0]   amask_ff, amask_in;
   logic [31:0]   fid_ff, fid_in;

   ffba_pkg::entry_type e_ff, e_in;
   ffba_pkg::entry_type p_ff, p_in;
   ffba_pkg::entry_type n_ff, n_in;
   logic [31:0]   pad_ff, pad_in;
   logic [32:0]   sum_ff, sum_in;
   logic [31:0]   al_ff, al_in;
   logic [31:0]   rest_ff, rest_in;
   logic [31:0]   acc_ff, acc_in;

   logic [2:0]    res_status_ff, res_status_in;
   logic [31:0]   res_off_ff, res_off_in;
   logic [31:0]   res_size_ff, res_size_in;
   logic [31:0]   res_id_ff, res_id_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_off_ff, rsp_off_in;
   logic [31:0]   rsp_size_ff, rsp_size_in;
   logic [31:0]   rsp_id_ff, rsp_id_in;
   logic [31:0]   rsp_used_ff, rsp_used_in;

   ffba_pkg::add_op_type add_op;
   logic [33:0]   add_sum;

   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   ffba_pkg::entry_type mem_wr_data, mem_rd_data;

   logic          fit;
   logic [CW:0]   k_src;
   logic          mrg_pf, mrg_nf;

   ffba_adder u_adder (
      .op  (add_op),
      .sum (add_sum)
   );

   ffba_table #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready        = (state_ff == S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_offset       = rsp_off_ff;
   assign rsp_granted_size = rsp_size_ff;
   assign rsp_block_id     = rsp_id_ff;
   assign rsp_used_bytes   = rsp_used_ff;

   // free neighbors of the released entry
   assign mrg_pf = (found_ff != '0) && !p_ff.busy;
   assign mrg_nf = (found_ff + ONE < count_ff) && !n_ff.busy;

   // shared adder operand select
   always_comb begin
      add_op = '0;
      unique case (state_ff)
         S_A_PAD:  begin
            add_op.a = {1'b0, ~mem_rd_data.offset};
            add_op.b = 33'd1;
         end
         S_A_CMP:  begin
            add_op.a = {1'b0, pad_ff};
            add_op.b = {1'b0, size_ff};
         end
         S_A_DEC:  begin
            add_op.a = {1'b0, e_ff.offset};
            add_op.b = {1'b0, pad_ff};
         end
         S_A_REST: begin
            add_op.a   = {1'b0, e_ff.size};
            add_op.b   = sum_ff;
            add_op.sub = 1'b1;
         end
         S_A_WR1:  begin
            add_op.a = {1'b0, al_ff};
            add_op.b = {1'b0, size_ff};
         end
         S_A_WR0:  begin
            add_op.a = {1'b0, used_ff};
            add_op.b = {1'b0, size_ff};
         end
         S_F_PCAP: begin
            add_op.a   = {1'b0, used_ff};
            add_op.b   = {1'b0, e_ff.size};
            add_op.sub = 1'b1;
         end
         S_F_MRG:  begin
            add_op.a = {1'b0, mrg_pf ? p_ff.size : e_ff.size};
            add_op.b = {1'b0, mrg_pf ? e_ff.size : (mrg_nf ? n_ff.size : 32'd0)};
         end
         S_F_MRG2: begin
            add_op.a = {1'b0, acc_ff};
            add_op.b = {1'b0, (pf_ff && nf_ff) ? n_ff.size : 32'd0};
         end
         default:  add_op = '0;
      endcase
   end

   assign fit   = !e_ff.busy && ({1'b0, e_ff.size} >= add_sum[32:0]);
   assign k_src = {1'b0, k_ff} + {{(CW-1){1'b0}}, rm_ff};

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      k_in          = k_ff;
      rm_in         = rm_ff;
      pf_in         = pf_ff;
      nf_in         = nf_ff;
      size_in       = size_ff;
      amask_in      = amask_ff;
      fid_in        = fid_ff;
      e_in          = e_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      pad_in        = pad_ff;
      sum_in        = sum_ff;
      al_in         = al_ff;
      rest_in       = rest_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_size_in   = res_size_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_used_in   = rsp_used_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;

      unique case (state_ff)
         S_INIT: begin
            mem_wr_en        = 1'b1;
            mem_wr_data.size = total_ff;
            count_in         = ONE;
            next_id_in       = 32'd1;
            used_in          = 32'd0;
            state_in         = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               size_in       = req_req_size;
               amask_in      = ~(32'hFFFF_FFFF << req_align_log2);
               fid_in        = req_free_id;
               idx_in        = '0;
               res_status_in = ffba_pkg::ST_OK;
               res_off_in    = '0;
               res_size_in   = '0;
               res_id_in     = '0;
               if (req_func == ffba_pkg::FUNC_FREE) begin
                  state_in = S_F_RD;
               end else if (req_req_size == 32'd0 || req_req_size >= total_ff) begin
                  res_status_in = ffba_pkg::ST_BADSIZE;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_A_RD;
               end
            end
         end
         S_A_RD: begin
            if (idx_ff == count_ff) begin
               res_status_in = ffba_pkg::ST_NOFIT;
               state_in      = S_OUT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[AW-1:0];
               state_in    = S_A_PAD;
            end
         end
         S_A_PAD: begin
            e_in     = mem_rd_data;
            pad_in   = add_sum[31:0] & amask_ff;
            state_in = S_A_CMP;
         end
         S_A_CMP: begin
            sum_in = add_sum[32:0];
            if (fit) begin
               found_in = idx_ff;
               state_in = S_A_DEC;
            end else begin
               idx_in   = idx_ff + ONE;
               state_in = S_A_RD;
            end
         end
         S_A_DEC: begin
            al_in = add_sum[31:0];
            k_in  = count_ff;
            if (e_ff.size == size_ff && pad_ff == 32'd0) begin
               // exact aligned fit, reuse entry as is
               mem_wr_en        = 1'b1;
               mem_wr_addr      = found_ff[AW-1:0];
               mem_wr_data      = e_ff;
               mem_wr_data.busy = 1'b1;
               al_in            = e_ff.offset;
               state_in         = S_A_WR0;
            end else if (count_ff >= MAX_CNT) begin
               res_status_in = ffba_pkg::ST_FULL;
               state_in      = S_OUT;
            end else begin
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            if (k_ff == found_ff + ONE) begin
               state_in = S_A_REST;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(k_ff - ONE);
               state_in    = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = k_ff[AW-1:0];
            mem_wr_data = mem_rd_data;
            k_in        = k_ff - ONE;
            state_in    = S_SH_RD;
         end
         S_A_REST: begin
            rest_in  = add_sum[31:0];
            state_in = S_A_WR1;
         end
         S_A_WR1: begin
            // free remainder after the granted block
            mem_wr_en          = 1'b1;
            mem_wr_addr        = AW'(found_ff + ONE);
            mem_wr_data.offset = add_sum[31:0];
            mem_wr_data.size   = rest_ff;
            mem_wr_data.ident  = next_id_ff;
            mem_wr_data.busy   = 1'b0;
            next_id_in         = next_id_ff + 32'd1;
            count_in           = count_ff + ONE;
            state_in           = S_A_WR0;
         end
         S_A_WR0: begin
            if (count_ff != k_ff) begin
               // split path: granted entry still to be written
               mem_wr_en          = 1'b1;
               mem_wr_addr        = found_ff[AW-1:0];
               mem_wr_data.offset = al_ff;
               mem_wr_data.size   = size_ff;
               mem_wr_data.ident  = e_ff.ident;
               mem_wr_data.busy   = 1'b1;
            end
            used_in     = add_sum[31:0];
            res_off_in  = al_ff;
            res_size_in = size_ff;
            res_id_in   = e_ff.ident;
            state_in    = S_OUT;
         end
         S_F_RD: begin
            if (idx_ff == count_ff) begin
               res_status_in = ffba_pkg::ST_BADID;
               state_in      = S_OUT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[AW-1:0];
               state_in    = S_F_CMP;
            end
         end
         S_F_CMP: begin
            e_in = mem_rd_data;
            if (mem_rd_data.ident == fid_ff) begin
               found_in = idx_ff;
               if (!mem_rd_data.busy) begin
                  res_status_in = ffba_pkg::ST_BADID;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_F_PRD;
               end
            end else begin
               idx_in   = idx_ff + ONE;
               state_in = S_F_RD;
            end
         end
         S_F_PRD: begin
            mem_rd_en   = (found_ff != '0);
            mem_rd_addr = AW'(found_ff - ONE);
            state_in    = S_F_PCAP;
         end
         S_F_PCAP: begin
            p_in        = mem_rd_data;
            mem_rd_en   = (found_ff + ONE < count_ff);
            mem_rd_addr = AW'(found_ff + ONE);
            used_in     = add_sum[31:0];
            res_off_in  = e_ff.offset;
            res_size_in = e_ff.size;
            res_id_in   = fid_ff;
            state_in    = S_F_NCAP;
         end
         S_F_NCAP: begin
            n_in     = mem_rd_data;
            state_in = S_F_MRG;
         end
         S_F_MRG: begin
            // table never holds two adjacent free entries before a release
            pf_in    = mrg_pf;
            nf_in    = mrg_nf;
            acc_in   = add_sum[31:0];
            rm_in    = {1'b0, mrg_pf} + {1'b0, mrg_nf};
            k_in     = mrg_pf ? found_ff : found_ff + ONE;
            state_in = S_F_MRG2;
         end
         S_F_MRG2: begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = AW'(k_ff - ONE);
            mem_wr_data.offset = pf_ff ? p_ff.offset : e_ff.offset;
            mem_wr_data.size   = add_sum[31:0];
            mem_wr_data.ident  = pf_ff ? p_ff.ident : e_ff.ident;
            mem_wr_data.busy   = 1'b0;
            state_in           = S_C_RD;
         end
         S_C_RD: begin
            if (rm_ff == 2'd0 || k_src >= {1'b0, count_ff}) begin
               count_in = count_ff - CW'(rm_ff);
               state_in = S_OUT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_src[AW-1:0];
               state_in    = S_C_WR;
            end
         end
         S_C_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = k_ff[AW-1:0];
            mem_wr_data = mem_rd_data;
            k_in        = k_ff + ONE;
            state_in    = S_C_RD;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               rsp_size_in   = res_size_ff;
               rsp_id_in     = res_id_ff;
               rsp_used_in   = used_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase

      if (csr_valid) begin
         total_in = csr_total_bytes & ffba_pkg::SIZE_MASK;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         total_ff     <= ffba_pkg::TOTAL_RESET;
         count_ff     <= ONE;
         next_id_ff   <= 32'd1;
         used_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      k_ff          <= k_in;
      rm_ff         <= rm_in;
      pf_ff         <= pf_in;
      nf_ff         <= nf_in;
      size_ff       <= size_in;
      amask_ff      <= amask_in;
      fid_ff        <= fid_in;
      e_ff          <= e_in;
      p_ff          <= p_in;
      n_ff          <= n_in;
      pad_ff        <= pad_in;
      sum_ff        <= sum_in;
      al_ff         <= al_in;
      rest_ff       <= rest_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_size_ff   <= res_size_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_used_ff   <= rsp_used_in;
   end

endmodule

/* test/first_fit_block_allocator_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit allocator. A queue-fed driver issues
// allocate and free requests, a monitor checks each response against an
// in-bench model of the block table, and the region size is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic        func;
      logic [31:0] size;
      logic [4:0]  align;
      logic [31:0] id;
   } alloc_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] offset;
      logic [31:0] size;
      logic [31:0] id;
      logic [31:0] used;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = ffba_pkg::FUNC_ALLOC;
   logic [31:0] req_req_size = '0;
   logic [4:0]  req_align_log2 = '0;
   logic [31:0] req_free_id = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_offset;
   logic [31:0] rsp_granted_size;
   logic [31:0] rsp_block_id;
   logic [31:0] rsp_used_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_total_bytes = '0;

   first_fit_block_allocator #(.MAX_ENTRIES(TABLE_DEPTH)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model of the block table
   logic [31:0] tbl_off [TABLE_DEPTH];
   logic [31:0] tbl_size [TABLE_DEPTH];
   logic [31:0] tbl_id [TABLE_DEPTH];
   logic        tbl_busy [TABLE_DEPTH];
   int          tbl_count;
   logic [31:0] region_bytes;
   logic [31:0] ident_next;
   logic [31:0] bytes_used;

   alloc_req_type pending_reqs[$];
   grant_type     awaited_grants[$];
   int          errors = 0;
   int          accepted = 0;
   int          checked = 0;
   int          status_seen [8];
   bit          no_idle = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          gap_left = 0;
   int          cycles = 0;

   function automatic void table_reset(logic [31:0] total);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_off[i] = '0;
         tbl_size[i] = '0;
         tbl_id[i] = '0;
         tbl_busy[i] = 1'b0;
      end
      region_bytes = total & ffba_pkg::SIZE_MASK;
      tbl_size[0] = region_bytes;
      tbl_count = 1;
      ident_next = 32'd1;
      bytes_used = '0;
   endfunction

   function automatic void move_entry(int dst, int src);
      tbl_off[dst] = tbl_off[src];
      tbl_size[dst] = tbl_size[src];
      tbl_id[dst] = tbl_id[src];
      tbl_busy[dst] = tbl_busy[src];
   endfunction

   function automatic void merge_free_runs();
      int i;
      i = 0;
      while (i + 1 < tbl_count) begin
         if (!tbl_busy[i] && !tbl_busy[i+1]) begin
            tbl_size[i] = tbl_size[i] + tbl_size[i+1];
            for (int k = i + 1; k + 1 < tbl_count; k++) move_entry(k, k + 1);
            tbl_count--;
            tbl_off[tbl_count] = '0;
            tbl_size[tbl_count] = '0;
            tbl_id[tbl_count] = '0;
            tbl_busy[tbl_count] = 1'b0;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic grant_type model_request(alloc_req_type r);
      grant_type g;
      logic [63:0] amask, al, pd, aligned, pad;
      int found;
      g = '{ffba_pkg::ST_OK, 32'd0, 32'd0, 32'd0, 32'd0};
      found = tbl_count;
      aligned = 0;
      pad = 0;
      if (r.func == ffba_pkg::FUNC_ALLOC) begin
         amask = (64'd1 << r.align) - 64'd1;
         if (r.size == 0 || r.size >= region_bytes) begin
            g.status = ffba_pkg::ST_BADSIZE;
         end else begin
            for (int i = 0; i < tbl_count; i++) begin
               al = ({32'd0, tbl_off[i]} + amask) & ~amask;
               pd = al - tbl_off[i];
               if (!tbl_busy[i] && {32'd0, tbl_size[i]} >= pd + r.size) begin
                  found = i;
                  aligned = al;
                  pad = pd;
                  break;
               end
            end
            if (found >= tbl_count) begin
               g.status = ffba_pkg::ST_NOFIT;
            end else if (tbl_size[found] == r.size && pad == 0) begin
               tbl_busy[found] = 1'b1;
            end else if (tbl_count >= TABLE_DEPTH) begin
               g.status = ffba_pkg::ST_FULL;
            end else begin
               for (int k = tbl_count; k > found + 1; k--) move_entry(k, k - 1);
               tbl_off[found+1] = aligned[31:0] + r.size;
               tbl_size[found+1] = 32'(tbl_size[found] - pad - r.size);
               tbl_id[found+1] = ident_next;
               tbl_busy[found+1] = 1'b0;
               ident_next = ident_next + 1;
               tbl_count++;
               tbl_off[found] = aligned[31:0];
               tbl_size[found] = r.size;
               tbl_busy[found] = 1'b1;
            end
            if (g.status == ffba_pkg::ST_OK) begin
               bytes_used = bytes_used + tbl_size[found];
               g.offset = tbl_off[found];
               g.size = tbl_size[found];
               g.id = tbl_id[found];
            end
         end
      end else begin
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_id[i] == r.id) begin
               found = i;
               break;
            end
         end
         if (found >= tbl_count || !tbl_busy[found]) begin
            g.status = ffba_pkg::ST_BADID;
         end else begin
            g.offset = tbl_off[found];
            g.size = tbl_size[found];
            g.id = r.id;
            tbl_busy[found] = 1'b0;
            bytes_used = bytes_used - g.size;
            merge_free_runs();
         end
      end
      g.used = bytes_used;
      return g;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("mismatch on response %0d: %s expected %h got %h", checked, field, want, got);
      errors++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_grants.push_back(model_request('{req_func, req_req_size,
                                                     req_align_log2, req_free_id}));
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               alloc_req_type it;
               it = pending_reqs.pop_front();
               req_func <= it.func;
               req_req_size <= it.size;
               req_align_log2 <= it.align;
               req_free_id <= it.id;
               req_valid <= 1'b1;
               gap_left <= gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            grant_type w;
            if (awaited_grants.size() == 0) begin
               report_mismatch("unexpected response", 32'd0, {29'd0, rsp_status});
            end else begin
               w = awaited_grants.pop_front();
               status_seen[w.status]++;
               if (rsp_status !== w.status)
                  report_mismatch("status", {29'd0, w.status}, {29'd0, rsp_status});
               if (rsp_offset !== w.offset) report_mismatch("offset", w.offset, rsp_offset);
               if (rsp_granted_size !== w.size)
                  report_mismatch("granted_size", w.size, rsp_granted_size);
               if (rsp_block_id !== w.id) report_mismatch("block_id", w.id, rsp_block_id);
               if (rsp_used_bytes !== w.used)
                  report_mismatch("used_bytes", w.used, rsp_used_bytes);
            end
            checked++;
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            stall_left = gap_len();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // sampled mid-cycle so the driver's updates at the edge have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || awaited_grants.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_region(logic [31:0] value);
      wait_idle();
      csr_total_bytes <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      table_reset(value);
   endtask

   task automatic push_req(logic func, logic [31:0] size, logic [4:0] align,
                           logic [31:0] id);
      pending_reqs.push_back('{func, size, align, id});
   endtask

   // picks a live block id most of the time, so frees reach the merge logic
   task automatic push_random(int alloc_pct);
      logic [31:0] size, id;
      logic [4:0]  align;
      int          r, live[$], lim;
      while (pending_reqs.size() > 1) @(posedge clock);
      r = $urandom_range(0, 99);
      lim = (region_bytes >> 4) > 1 ? region_bytes >> 4 : 1;
      if (r < alloc_pct) begin
         r = $urandom_range(0, 99);
         if (r < 4) size = 0;
         else if (r < 7) size = region_bytes;
         else if (r < 9) size = 32'hFFFF_FFFF;
         else if (r < 11) size = region_bytes - 1;
         else if (r < 50) size = $urandom_range(1, 256);
         else size = $urandom_range(1, lim);
         align = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
         push_req(ffba_pkg::FUNC_ALLOC, size, align, $urandom());
      end else begin
         for (int i = 0; i < tbl_count; i++) if (tbl_busy[i]) live.push_back(i);
         r = $urandom_range(0, 99);
         if (live.size() > 0 && r < 80) id = tbl_id[live[$urandom_range(0, live.size() - 1)]];
         else if (r < 90) id = $urandom_range(0, ident_next);
         else id = $urandom();
         push_req(ffba_pkg::FUNC_FREE, $urandom(), 5'($urandom()), id);
      end
   endtask

   initial begin
      table_reset(ffba_pkg::TOTAL_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: bad sizes, alignments, frees of unknown and idle ids
      push_req(ffba_pkg::FUNC_ALLOC, 32'd0, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, ffba_pkg::TOTAL_RESET, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd1, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd100, 5'd16, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd64, 5'd31, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, ffba_pkg::TOTAL_RESET - 1, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_FREE, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd2);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd1);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd1, 5'd0, 32'd0);
      wait_idle();

      // small region: zero remainder after padding, then an exact refit
      write_region(32'd4096 | 32'h3F);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd64, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd3968, 5'd7, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd8, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd64, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd1);
      push_req(ffba_pkg::FUNC_FREE, 32'd0, 5'd0, 32'd0);
      push_req(ffba_pkg::FUNC_ALLOC, 32'd4095, 5'd0, 32'd0);
      for (int n = 0; n < 110; n++) push_random(55);

      write_region(ffba_pkg::TOTAL_RESET);
      for (int n = 0; n < 150; n++) begin
         if (n == 40) hold_request = 1;
         push_random(55);
      end

      no_idle = 1;
      write_region(32'd64);
      for (int n = 0; n < 40; n++) push_random(60);
      write_region(32'd0);
      for (int n = 0; n < 15; n++) push_random(70);
      no_idle = 0;

      write_region(32'hFFFF_FFFF);
      for (int n = 0; n < 140; n++) push_random(55);

      // fill the table until it reports full, then drain it
      write_region(32'd1 << 20);
      for (int n = 0; n < 85; n++)
         push_req(ffba_pkg::FUNC_ALLOC, $urandom_range(1, 512),
                  5'($urandom_range(0, 4)), 32'd0);
      for (int n = 0; n < 60; n++) push_random(20);

      wait_idle();
      repeat (50) @(posedge clock);
      $display("%0d requests, %0d responses checked over six region sizes", accepted, checked);
      $display("status counts ok %0d nofit %0d full %0d badid %0d badsize %0d",
               status_seen[ffba_pkg::ST_OK], status_seen[ffba_pkg::ST_NOFIT],
               status_seen[ffba_pkg::ST_FULL], status_seen[ffba_pkg::ST_BADID],
               status_seen[ffba_pkg::ST_BADSIZE]);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
